// File: rtl/encoder_position_pid_with_deadband_top_defines.svh
// Assertion macros shared by the servo block.
`ifndef ENCODER_POSITION_PID_WITH_DEADBAND_TOP_DEFINES_SVH
`define ENCODER_POSITION_PID_WITH_DEADBAND_TOP_DEFINES_SVH

// Same-cycle implication.
`define ENCPID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication.
`define ENCPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: rtl/encpid_pkg.sv
package encpid_pkg;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_POSITION = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_P          = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_I          = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_D          = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DUTY_LIMIT      = 3'd5;

   localparam logic signed [31:0] TARGET_RESET     = 32'sd0;
   localparam logic [15:0]        TOLERANCE_RESET  = 16'd5;
   localparam logic [15:0]        GAIN_P_RESET     = 16'd7168;
   localparam logic [15:0]        GAIN_I_RESET     = 16'd37;
   localparam logic [15:0]        GAIN_D_RESET     = 16'd5325;
   localparam logic [7:0]         DUTY_LIMIT_RESET = 8'd200;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] DRIVE_STOP     = 2'd0;
   localparam logic [1:0] DRIVE_FORWARD  = 2'd1;
   localparam logic [1:0] DRIVE_BACKWARD = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic               tick;
      logic               in_band;
      logic signed [31:0] err;
      logic signed [31:0] esum;
      logic signed [32:0] deriv;
      logic [31:0]        pos_now;
   } stage_one_type;

   typedef struct packed {
      logic               tick;
      logic               in_band;
      logic               err_neg;
      logic signed [48:0] prod_p;
      logic signed [48:0] prod_i;
      logic signed [49:0] prod_d;
      logic [31:0]        pos_now;
   } stage_two_type;

endpackage

// File: rtl/encoder_position_pid_with_deadband_top.sv
// Each accepted item passes three register stages (s1, s2, rsp) before rsp_tvalid rises.
// Throughput: one item per cycle unless rsp stalls; the three gain multiplies sit in their own stage.
// Stages stall independently, so bubbles close up under rsp backpressure.
// Reset (synchronous, active high): position, integral, previous error and held
// outputs clear to zero; registers return to their default values.
`include "encoder_position_pid_with_deadband_top_defines.svh"

module encoder_position_pid_with_deadband_top #(
   parameter int COUNT_BITS     = 32,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [0] channel_b
   input  logic [0:0]                          req_tuser,  // [0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,  // [7:0] duty, [9:8] drive,
                                                           // [41:10] position_now, [42] on_target
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [encpid_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_data
);
   import encpid_pkg::*;

   localparam int EXT_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

   logic signed [31:0] target_ff;
   logic [15:0]        tolerance_ff;
   logic [15:0]        gain_p_ff;
   logic [15:0]        gain_i_ff;
   logic [15:0]        gain_d_ff;
   logic [7:0]         duty_limit_ff;

   logic signed [COUNT_BITS-1:0] position_ff;
   logic signed [31:0]           esum_ff;
   logic signed [31:0]           last_ff;

   logic          s1_valid_ff;
   logic          s2_valid_ff;
   logic          rsp_valid_ff;
   stage_one_type s1_ff;
   stage_one_type s1_in;
   stage_two_type s2_ff;
   stage_two_type s2_in;

   logic [7:0]  held_duty_ff;
   logic [1:0]  held_drive_ff;
   logic        held_on_target_ff;
   logic [31:0] pos_out_ff;

   logic en1;
   logic en2;
   logic en3;
   logic req_accept;

   logic signed [COUNT_BITS-1:0] pos_step;
   logic signed [COUNT_BITS-1:0] pos_after;
   logic signed [EXT_BITS-1:0]   pos_ext;
   logic signed [EXT_BITS-1:0]   error_wide;
   logic signed [31:0]           err;
   logic [31:0]                  abs_err;
   logic                         in_band;
   logic signed [32:0]           esum_wide;
   logic signed [31:0]           esum_new;

   logic signed [51:0] pid_sum;
   logic [51:0]        pid_mag;
   logic [51:0]        pid_shift;
   logic [7:0]         duty_calc;

   // csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TARGET_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         duty_limit_ff <= DUTY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_POSITION: target_ff     <= csr_data;
            CSR_TOLERANCE:       tolerance_ff  <= csr_data[15:0];
            CSR_GAIN_P:          gain_p_ff     <= csr_data[15:0];
            CSR_GAIN_I:          gain_i_ff     <= csr_data[15:0];
            CSR_GAIN_D:          gain_d_ff     <= csr_data[15:0];
            CSR_DUTY_LIMIT:      duty_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // stage enables
   assign en3        = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign req_accept = req_tvalid && req_tready;

   // stage 1: position, error, integral, derivative
   always_comb begin
      pos_step   = req_tdata[0] ? (position_ff + COUNT_BITS'(1))
                                : (position_ff - COUNT_BITS'(1));
      error_wide = EXT_BITS'(target_ff) - EXT_BITS'(position_ff);
      if ((&error_wide[EXT_BITS-1:31]) || !(|error_wide[EXT_BITS-1:31])) begin
         err = error_wide[31:0];
      end else begin
         err = error_wide[EXT_BITS-1] ? S32_MIN : S32_MAX;
      end
      abs_err   = err[31] ? (~err + 32'd1) : err;
      in_band   = ({16'd0, tolerance_ff} >= abs_err);
      esum_wide = 33'(esum_ff) + 33'(err);
      if (esum_wide[32] == esum_wide[31]) begin
         esum_new = esum_wide[31:0];
      end else begin
         esum_new = esum_wide[32] ? S32_MIN : S32_MAX;
      end
      pos_after = (req_tuser[0] == KIND_EDGE) ? pos_step : position_ff;
      pos_ext   = EXT_BITS'(pos_after);

      s1_in.tick    = (req_tuser[0] == KIND_TICK);
      s1_in.in_band = in_band;
      s1_in.err     = err;
      s1_in.esum    = esum_new;
      s1_in.deriv   = 33'(err) - 33'(last_ff);
      s1_in.pos_now = pos_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         esum_ff     <= '0;
         last_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (req_accept) begin
            if (req_tuser[0] == KIND_EDGE) begin
               position_ff <= pos_step;
            end else if (!in_band) begin
               esum_ff <= esum_new;
               last_ff <= err;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: gain products
   always_comb begin
      s2_in.tick    = s1_ff.tick;
      s2_in.in_band = s1_ff.in_band;
      s2_in.err_neg = s1_ff.err[31];
      s2_in.prod_p  = $signed({1'b0, gain_p_ff}) * s1_ff.err;
      s2_in.prod_i  = $signed({1'b0, gain_i_ff}) * s1_ff.esum;
      s2_in.prod_d  = $signed({1'b0, gain_d_ff}) * s1_ff.deriv;
      s2_in.pos_now = s1_ff.pos_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: sum, magnitude, saturate
   always_comb begin
      pid_sum   = 52'(s2_ff.prod_p) + 52'(s2_ff.prod_i) + 52'(s2_ff.prod_d);
      pid_mag   = pid_sum[51] ? (~pid_sum + 52'd1) : pid_sum;
      pid_shift = pid_mag >> GAIN_FRAC_BITS;
      duty_calc = (pid_shift > 52'(duty_limit_ff)) ? duty_limit_ff : pid_shift[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         held_duty_ff      <= '0;
         held_drive_ff     <= DRIVE_STOP;
         held_on_target_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff && s2_ff.tick) begin
            if (s2_ff.in_band) begin
               held_duty_ff      <= '0;
               held_drive_ff     <= DRIVE_STOP;
               held_on_target_ff <= 1'b1;
            end else begin
               held_duty_ff      <= duty_calc;
               held_drive_ff     <= s2_ff.err_neg ? DRIVE_BACKWARD : DRIVE_FORWARD;
               held_on_target_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         pos_out_ff <= s2_ff.pos_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, held_on_target_ff, pos_out_ff, held_drive_ff, held_duty_ff};

   `ENCPID_ASSERT_IMP(a_stop_means_zero_duty, clock, reset,
      held_drive_ff == DRIVE_STOP, held_duty_ff == 8'd0)
   `ENCPID_ASSERT_IMP(a_on_target_means_stop, clock, reset,
      held_on_target_ff, held_drive_ff == DRIVE_STOP)
   `ENCPID_ASSERT_NEXT(a_tick_keeps_position, clock, reset,
      req_accept && (req_tuser[0] == KIND_TICK), $stable(position_ff))
   `ENCPID_ASSERT_NEXT(a_edge_moves_position, clock, reset,
      req_accept && (req_tuser[0] == KIND_EDGE), position_ff != $past(position_ff))
   `ENCPID_ASSERT_NEXT(a_stalled_stage_holds, clock, reset,
      s1_valid_ff && !en2, s1_valid_ff)

endmodule

// File: sim/servo_checker.sv
module servo_checker #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [0] channel_b
   input  logic [0:0]                            req_tuser,  // [0] kind
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [47:0]                           rsp_tdata,  // [7:0] duty, [9:8] drive,
                                                             // [41:10] position_now, [42] on_target
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [encpid_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                           csr_data,
   output int                                    mismatches,
   output int                                    pending
);
   import encpid_pkg::*;

   typedef struct packed {
      logic [7:0]  duty;
      logic [1:0]  drive;
      logic [31:0] pos_now;
      logic        on_target;
   } servo_output_type;

   logic signed [31:0] target_q;
   logic [15:0]        tol_q;
   logic [15:0]        kp_q;
   logic [15:0]        ki_q;
   logic [15:0]        kd_q;
   logic [7:0]         duty_max_q;

   logic signed [31:0] position_q;
   logic signed [31:0] integral_q;
   logic signed [31:0] prev_error_q;
   logic [7:0]         held_duty_q;
   logic [1:0]         held_drive_q;
   logic               held_on_target_q;

   servo_output_type pending_drive_outputs[$];

   function automatic longint clamp32(input longint v);
      if (v > longint'(S32_MAX)) return longint'(S32_MAX);
      if (v < longint'(S32_MIN)) return longint'(S32_MIN);
      return v;
   endfunction

   function automatic servo_output_type servo_step(input logic kind, input logic chb);
      longint           err;
      longint           abs_err;
      longint           pid_sum;
      longint           mag;
      servo_output_type res;
      if (kind == KIND_EDGE) begin
         position_q = chb ? position_q + 32'sd1 : position_q - 32'sd1;
      end else begin
         err = clamp32(longint'(target_q) - longint'(position_q));
         abs_err = (err < 0) ? -err : err;
         if (abs_err <= longint'(tol_q)) begin
            held_duty_q = 8'd0;
            held_drive_q = DRIVE_STOP;
            held_on_target_q = 1'b1;
         end else begin
            integral_q = 32'(clamp32(longint'(integral_q) + err));
            pid_sum = longint'(kp_q) * err + longint'(ki_q) * longint'(integral_q)
                    + longint'(kd_q) * (err - longint'(prev_error_q));
            mag = (pid_sum < 0) ? -pid_sum : pid_sum;
            mag = mag >>> GAIN_FRAC_BITS;
            held_duty_q = (mag > longint'(duty_max_q)) ? duty_max_q : 8'(mag);
            prev_error_q = 32'(err);
            held_drive_q = (err > 0) ? DRIVE_FORWARD : DRIVE_BACKWARD;
            held_on_target_q = 1'b0;
         end
      end
      res.duty = held_duty_q;
      res.drive = held_drive_q;
      res.pos_now = position_q;
      res.on_target = held_on_target_q;
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      servo_output_type want;
      servo_output_type got;
      if (reset) begin
         target_q = TARGET_RESET;
         tol_q = TOLERANCE_RESET;
         kp_q = GAIN_P_RESET;
         ki_q = GAIN_I_RESET;
         kd_q = GAIN_D_RESET;
         duty_max_q = DUTY_LIMIT_RESET;
         position_q = '0;
         integral_q = '0;
         prev_error_q = '0;
         held_duty_q = '0;
         held_drive_q = DRIVE_STOP;
         held_on_target_q = 1'b0;
         pending_drive_outputs.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_POSITION: target_q = csr_data;
               CSR_TOLERANCE:       tol_q = csr_data[15:0];
               CSR_GAIN_P:          kp_q = csr_data[15:0];
               CSR_GAIN_I:          ki_q = csr_data[15:0];
               CSR_GAIN_D:          kd_q = csr_data[15:0];
               CSR_DUTY_LIMIT:      duty_max_q = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_drive_outputs.push_back(servo_step(req_tuser[0], req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            got.duty = rsp_tdata[7:0];
            got.drive = rsp_tdata[9:8];
            got.pos_now = rsp_tdata[41:10];
            got.on_target = rsp_tdata[42];
            if (pending_drive_outputs.size() == 0) begin
               flag_mismatch("rsp item with nothing outstanding");
            end else begin
               want = pending_drive_outputs.pop_front();
               if (got.duty !== want.duty)
                  flag_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
               if (got.drive !== want.drive)
                  flag_mismatch($sformatf("drive %0d, want %0d", got.drive, want.drive));
               if (got.pos_now !== want.pos_now)
                  flag_mismatch($sformatf("position_now %0d, want %0d",
                                          $signed(got.pos_now), $signed(want.pos_now)));
               if (got.on_target !== want.on_target)
                  flag_mismatch($sformatf("on_target %0b, want %0b",
                                          got.on_target, want.on_target));
            end
         end
         pending <= pending_drive_outputs.size();
      end
   end

endmodule

// File: sim/tb.sv
module tb;
   import encpid_pkg::*;

   localparam int GAIN_FRAC       = 12;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 300000;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;  // [0] channel_b
   logic [0:0]                req_tuser;  // [0] kind
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [47:0]               rsp_tdata;  // [7:0] duty, [9:8] drive,
                                          // [41:10] position_now, [42] on_target
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]               csr_data;

   int mismatches;
   int pending;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_off_request = 1'b0;
   int cycle_count = 0;
   int track_pos = 0;
   int cur_target = 0;

   encoder_position_pid_with_deadband_top #(
      .COUNT_BITS(32),
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) uut (.*);

   servo_checker #(
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) servo_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(1, 100) <= rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic kind, input logic chb);
      if ($urandom_range(1, 100) <= req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, chb};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_EDGE) track_pos += chb ? 1 : -1;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int target, input logic [15:0] tol,
                                input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [7:0] dmax);
      settle();
      write_reg(CSR_TARGET_POSITION, target);
      write_reg(CSR_TOLERANCE, {16'($urandom), tol});
      write_reg(CSR_GAIN_P, {16'($urandom), kp});
      write_reg(CSR_GAIN_I, {16'($urandom), ki});
      write_reg(CSR_GAIN_D, {16'($urandom), kd});
      write_reg(CSR_DUTY_LIMIT, {24'($urandom), dmax});
      cur_target = target;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 8192));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_setting();
      int          target;
      logic [15:0] tol;
      logic [7:0]  dmax;
      case ($urandom_range(0, 7))
         0:       target = S32_MAX;
         1:       target = S32_MIN;
         2:       target = $urandom;
         default: target = track_pos + int'($urandom_range(0, 120)) - 60;
      endcase
      case ($urandom_range(0, 5))
         0:       tol = 16'd0;
         1:       tol = 16'hFFFF;
         2:       tol = 16'($urandom);
         default: tol = 16'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 4))
         0:       dmax = 8'd0;
         1:       dmax = 8'hFF;
         default: dmax = 8'($urandom);
      endcase
      apply_setting(target, tol, pick_gain(), pick_gain(), pick_gain(), dmax);
   endtask

   // Mostly runs of edges heading toward the target, closed by a tick; some noise.
   task automatic run_phase(input int count);
      int   left;
      int   run_len;
      logic up;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 8) begin
            up = ($urandom_range(0, 9) < 6) ? (track_pos < cur_target) : 1'($urandom);
            run_len = $urandom_range(0, 8);
            for (int k = 0; k < run_len && left > 0; k++) begin
               send_item(KIND_EDGE, ($urandom_range(0, 9) == 0) ? ~up : up);
               left--;
            end
            if (left > 0) begin
               send_item(KIND_TICK, 1'($urandom));
               left--;
            end
         end else begin
            send_item(1'($urandom), 1'($urandom));
            left--;
         end
      end
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 40;
      endcase
   endfunction

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_EDGE;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TARGET_POSITION;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 10;
      rsp_idle_pct = 10;
      send_item(KIND_TICK, 1'b1);
      send_item(KIND_EDGE, 1'b1);
      send_item(KIND_EDGE, 1'b0);

      apply_setting(100, TOLERANCE_RESET, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                    DUTY_LIMIT_RESET);
      send_item(KIND_TICK, 1'b0);
      send_item(KIND_TICK, 1'b0);
      send_item(KIND_EDGE, 1'b0);
      send_item(KIND_TICK, 1'b0);

      apply_setting(-100, TOLERANCE_RESET, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                    DUTY_LIMIT_RESET);
      repeat (2) send_item(KIND_TICK, 1'b0);

      // error and integral pinned at the positive rail
      apply_setting(S32_MAX, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_item(KIND_EDGE, 1'b0);
      repeat (3) send_item(KIND_TICK, 1'b0);

      // and at the negative rail
      apply_setting(S32_MIN, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      repeat (3) send_item(KIND_EDGE, 1'b1);
      repeat (3) send_item(KIND_TICK, 1'b0);

      apply_setting(track_pos + 7, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      send_item(KIND_TICK, 1'b0);

      // error exactly at the widest stop band, then one count past it
      apply_setting(track_pos - 65535, 16'hFFFF, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                    8'hFF);
      send_item(KIND_TICK, 1'b0);
      send_item(KIND_EDGE, 1'b1);
      send_item(KIND_TICK, 1'b0);

      apply_setting(track_pos, 16'd0, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET, 8'hFF);
      send_item(KIND_TICK, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         random_setting();
         if (p == PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = (p == 2) ? 0 : pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         if (p == 2) hold_off_request = 1'b1;
         run_phase(ITEMS_PER_PHASE);
      end
      settle();

      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
